### hw/rtl/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

  localparam int NUM_SNS     = 5;
  localparam int SMP_W       = 12;
  localparam int SPD_W       = 8;
  localparam int GAIN_W      = 24;
  localparam int ERR_W       = 4;
  localparam int DER_W       = ERR_W + 1;
  localparam int SUM_W       = 32;
  localparam int SIDE_W      = 2;
  localparam int PCT_W       = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = GAIN_W;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // PID datapath widths, gains are unsigned so they get one extra sign bit
  localparam int PP_W   = GAIN_W + 1 + ERR_W;
  localparam int PD_W   = GAIN_W + 1 + DER_W;
  localparam int PI_W   = GAIN_W + 1 + SUM_W;
  localparam int ACC_W  = PI_W + 1;
  localparam int FRAC_W = 16;
  localparam int TERM_W = ACC_W - FRAC_W;
  localparam int DRV_W  = TERM_W + 1;
  localparam int SPEED_W = 9;

  localparam int SEARCH_SPEED = 120;
  localparam int SPEED_LIMIT  = 255;
  localparam int PCT_SCALE    = 100;

  localparam logic [SMP_W-1:0]  THR_RST = SMP_W'(500);
  localparam logic [GAIN_W-1:0] KP_RST  = GAIN_W'(1966080);
  localparam logic [GAIN_W-1:0] KD_RST  = GAIN_W'(196608);
  localparam logic [GAIN_W-1:0] KI_RST  = GAIN_W'(655);

  localparam logic [SIDE_W-1:0] SIDE_CENTRE = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd2;

  localparam int SNS_FL = 0;
  localparam int SNS_NL = 1;
  localparam int SNS_C  = 2;
  localparam int SNS_NR = 3;
  localparam int SNS_FR = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THR_FL = 3'd0,
    REG_THR_NL = 3'd1,
    REG_THR_C  = 3'd2,
    REG_THR_NR = 3'd3,
    REG_THR_FR = 3'd4,
    REG_KP     = 3'd5,
    REG_KD     = 3'd6,
    REG_KI     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W-1:0] deriv;
    logic signed [SUM_W-1:0] sum;
    logic                    lost;
    logic [SIDE_W-1:0]       side;
  } track_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    lost;
    logic [SIDE_W-1:0]       side;
  } meta_t;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [DRV_W-1:0] v);
    if (v > DRV_W'(SPEED_LIMIT)) begin
      return SPEED_W'(SPEED_LIMIT);
    end else if (v < DRV_W'(-SPEED_LIMIT)) begin
      return SPEED_W'(-SPEED_LIMIT);
    end
    return SPEED_W'(v);
  endfunction

  // trunc(v*100/255) on the magnitude; x/255 = (x + (x>>8) + 1) >> 8 for x < 2^16
  function automatic logic signed [PCT_W-1:0] to_percent(
      input logic signed [SPEED_W-1:0] v);
    logic [SPEED_W-1:0] mag;
    logic [15:0]        prod;
    logic [15:0]        quo;
    logic [PCT_W-1:0]   pm;
    mag  = v[SPEED_W-1] ? SPEED_W'(-v) : SPEED_W'(v);
    prod = 16'(mag) * 16'(PCT_SCALE);
    quo  = (prod + (prod >> 8) + 16'd1) >> 8;
    pm   = quo[PCT_W-1:0];
    return v[SPEED_W-1] ? $signed(-pm) : $signed(pm);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lfpd_track.sv
`default_nettype none

module lfpd_track (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic [lfpd_pkg::NUM_SNS-1:0] sns_hit,
  output lfpd_pkg::track_t                  trk
);
  import lfpd_pkg::*;

  // previous error always equals the held error, so one register serves both
  logic signed [ERR_W-1:0] held_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SIDE_W-1:0]       side_r;

  logic signed [ERR_W-1:0] err_nxt;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SIDE_W-1:0]       side_nxt;
  logic signed [SUM_W:0]   sum_wide;
  logic                    any_hit;

  assign any_hit = |sns_hit;

  // later rules override earlier ones
  always_comb begin
    err_nxt = held_r;
    if (sns_hit[SNS_FL]) err_nxt = ERR_W'(-4);
    if (sns_hit[SNS_NL]) err_nxt = ERR_W'(-2);
    if (sns_hit[SNS_FL] && sns_hit[SNS_NL]) err_nxt = ERR_W'(-3);
    if (sns_hit[SNS_C]) err_nxt = ERR_W'(0);
    if (sns_hit[SNS_NL] && sns_hit[SNS_C]) err_nxt = ERR_W'(-1);
    if (sns_hit[SNS_NR]) err_nxt = ERR_W'(2);
    if (sns_hit[SNS_C] && sns_hit[SNS_NR]) err_nxt = ERR_W'(1);
    if (sns_hit[SNS_FR]) err_nxt = ERR_W'(4);
    if (sns_hit[SNS_NR] && sns_hit[SNS_FR]) err_nxt = ERR_W'(3);
  end

  always_comb begin
    side_nxt = side_r;
    if (sns_hit[SNS_NR] || sns_hit[SNS_FR]) side_nxt = SIDE_RIGHT;
    if (sns_hit[SNS_FL] || sns_hit[SNS_NL]) side_nxt = SIDE_LEFT;
  end

  always_comb begin
    sum_wide = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err_nxt);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    trk.err   = err_nxt;
    trk.deriv = DER_W'(err_nxt) - DER_W'(held_r);
    trk.sum   = sum_r;
    trk.lost  = !any_hit;
    trk.side  = side_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      sum_r  <= '0;
      side_r <= SIDE_CENTRE;
    end else if (adv && any_hit) begin
      held_r <= err_nxt;
      sum_r  <= sum_nxt;
      side_r <= side_nxt;
    end
  end

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r >= ERR_W'(-4) && held_r <= ERR_W'(4))
    else $error("held error out of range");

  a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
    side_r == SIDE_CENTRE || side_r == SIDE_LEFT || side_r == SIDE_RIGHT)
    else $error("bad side code");

  a_lost_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !any_hit |=> $stable(held_r) && $stable(sum_r) && $stable(side_r))
    else $error("state moved on a lost line");

  a_left_wins: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (sns_hit[SNS_FL] || sns_hit[SNS_NL]) |=> side_r == SIDE_LEFT)
    else $error("left side not recorded");

endmodule

`default_nettype wire

### hw/rtl/line_follower_pid_drive_top.sv
// Channel  Dir  Handshake                Payload
// in_      in   in_tvalid / in_tready    in_tdata: five samples, cruise speed
// out_     out  out_tvalid / out_tready  out_tdata: wheel percents, error, side;
//                                         out_tuser: line lost
// cfg_     in   cfg_we                   cfg_addr, cfg_wdata
//
// Six register stages: input, track/state update, multiply, accumulate,
// steer/clamp, percent. One request per cycle while the output is not stalled.
// Tracking state is updated as a request leaves the input stage, so
// consecutive requests see each other's state with no gap.
// Each stage stalls only when it holds data and the next one cannot take it.
// Reset (synchronous, rst_n low) empties the pipe and restores registers.
`default_nettype none

module line_follower_pid_drive_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [11:0] sample_far_left, [23:12] sample_near_left, [35:24] sample_center,
  // [47:36] sample_near_right, [59:48] sample_far_right, [67:60] cruise_speed
  input  wire logic [lfpd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [7:0] left_percent, [15:8] right_percent, [19:16] line_error, [21:20] seen_side
  output      logic [lfpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] line_lost
  output      logic                             out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [lfpd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lfpd_pkg::*;

  // configuration
  logic [SMP_W-1:0]  thr_r [NUM_SNS];
  logic [GAIN_W-1:0] kp_r;
  logic [GAIN_W-1:0] kd_r;
  logic [GAIN_W-1:0] ki_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SNS; i++) thr_r[i] <= THR_RST;
      kp_r <= KP_RST;
      kd_r <= KD_RST;
      ki_r <= KI_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr) inside
        REG_THR_FL, REG_THR_NL, REG_THR_C, REG_THR_NR, REG_THR_FR:
          thr_r[cfg_addr] <= cfg_wdata[SMP_W-1:0];
        REG_KP: kp_r <= cfg_wdata;
        REG_KD: kd_r <= cfg_wdata;
        REG_KI: ki_r <= cfg_wdata;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_r || out_tready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: input register
  logic [SMP_W-1:0] smp_r [NUM_SNS];
  logic [SPD_W-1:0] cruise1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      for (int i = 0; i < NUM_SNS; i++) smp_r[i] <= in_tdata[i*SMP_W +: SMP_W];
      cruise1_r <= in_tdata[NUM_SNS*SMP_W +: SPD_W];
    end
  end

  logic [NUM_SNS-1:0] sns_hit;
  track_t             trk;

  always_comb begin
    for (int i = 0; i < NUM_SNS; i++) sns_hit[i] = smp_r[i] <= thr_r[i];
  end

  lfpd_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (v1_r && rdy2),
    .sns_hit (sns_hit),
    .trk     (trk)
  );

  // stage 2: tracked error, products formed here
  track_t           trk2_r;
  logic [SPD_W-1:0] cruise2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      trk2_r    <= trk;
      cruise2_r <= cruise1_r;
    end
  end

  logic signed [PP_W-1:0] pp_nxt;
  logic signed [PD_W-1:0] pd_nxt;
  logic signed [PI_W-1:0] pi_nxt;

  assign pp_nxt = $signed({1'b0, kp_r}) * trk2_r.err;
  assign pd_nxt = $signed({1'b0, kd_r}) * trk2_r.deriv;
  assign pi_nxt = $signed({1'b0, ki_r}) * trk2_r.sum;

  // stage 3: products
  logic signed [PP_W-1:0] pp3_r;
  logic signed [PD_W-1:0] pd3_r;
  logic signed [PI_W-1:0] pi3_r;
  logic [SPD_W-1:0]       cruise3_r;
  meta_t                  meta3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      pp3_r        <= pp_nxt;
      pd3_r        <= pd_nxt;
      pi3_r        <= pi_nxt;
      cruise3_r    <= cruise2_r;
      meta3_r.err  <= trk2_r.err;
      meta3_r.lost <= trk2_r.lost;
      meta3_r.side <= trk2_r.side;
    end
  end

  logic signed [ACC_W-1:0] acc_nxt;
  assign acc_nxt = ACC_W'(pp3_r) + ACC_W'(pd3_r) + ACC_W'(pi3_r);

  // stage 4: Q.16 accumulator
  logic signed [ACC_W-1:0] acc4_r;
  logic [SPD_W-1:0]        cruise4_r;
  meta_t                   meta4_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      acc4_r    <= acc_nxt;
      cruise4_r <= cruise3_r;
      meta4_r   <= meta3_r;
    end
  end

  // floor shift plus one when negative with a fraction gives truncation to zero
  logic signed [TERM_W-1:0]  term_fl;
  logic                      term_rnd;
  logic signed [DRV_W-1:0]   cruise_x;
  logic signed [DRV_W-1:0]   lsum;
  logic signed [DRV_W-1:0]   rsum;
  logic signed [SPEED_W-1:0] lspd_nxt;
  logic signed [SPEED_W-1:0] rspd_nxt;
  logic signed [SPEED_W-1:0] search_spd;

  assign term_fl  = acc4_r[ACC_W-1:FRAC_W];
  assign term_rnd = acc4_r[ACC_W-1] && (|acc4_r[FRAC_W-1:0]);
  assign cruise_x = DRV_W'($signed({1'b0, cruise4_r}));
  assign lsum = cruise_x + DRV_W'(term_fl) + DRV_W'({1'b0, term_rnd});
  assign rsum = cruise_x - DRV_W'(term_fl) - DRV_W'({1'b0, term_rnd});
  assign search_spd = clamp_speed(DRV_W'(SEARCH_SPEED));

  always_comb begin
    if (!meta4_r.lost) begin
      lspd_nxt = clamp_speed(lsum);
      rspd_nxt = clamp_speed(rsum);
    end else begin
      case (meta4_r.side)
        SIDE_LEFT: begin
          lspd_nxt = -search_spd;
          rspd_nxt = search_spd;
        end
        SIDE_RIGHT: begin
          lspd_nxt = search_spd;
          rspd_nxt = -search_spd;
        end
        default: begin
          lspd_nxt = search_spd;
          rspd_nxt = search_spd;
        end
      endcase
    end
  end

  // stage 5: wheel speeds
  logic signed [SPEED_W-1:0] lspd5_r;
  logic signed [SPEED_W-1:0] rspd5_r;
  meta_t                     meta5_r;

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      lspd5_r <= lspd_nxt;
      rspd5_r <= rspd_nxt;
      meta5_r <= meta4_r;
    end
  end

  // stage 6: output register
  logic signed [PCT_W-1:0] lpct_r;
  logic signed [PCT_W-1:0] rpct_r;
  meta_t                   meta6_r;

  always_ff @(posedge clk) begin
    if (rdy6 && v5_r) begin
      lpct_r  <= to_percent(lspd5_r);
      rpct_r  <= to_percent(rspd5_r);
      meta6_r <= meta5_r;
    end
  end

  assign out_tvalid = v6_r;
  assign out_tuser  = meta6_r.lost;
  assign out_tdata  = {2'b00, meta6_r.side, meta6_r.err, rpct_r, lpct_r};

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> lpct_r >= PCT_W'(-PCT_SCALE) && lpct_r <= PCT_W'(PCT_SCALE)
                && rpct_r >= PCT_W'(-PCT_SCALE) && rpct_r <= PCT_W'(PCT_SCALE))
    else $error("percent out of range");

  a_search_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (lpct_r == to_percent(search_spd) || lpct_r == -to_percent(search_spd))
      && (rpct_r == to_percent(search_spd) || rpct_r == -to_percent(search_spd)))
    else $error("search speed wrong on lost line");

  a_input_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("input stalled with empty input stage");

endmodule

`default_nettype wire
